// ===== src/qdvc_pkg.sv =====
// Shared types and constants for the quadrature detent volume counter.
// No dependencies; imported by qdvc_core and the top level.
package qdvc_pkg;

  // Configuration register indexes
  localparam logic REG_VOLUME_FLOOR   = 1'b0;
  localparam logic REG_VOLUME_CEILING = 1'b1;

  // Reset values
  localparam logic [6:0] FLOOR_RESET   = 7'd0;
  localparam logic [6:0] CEILING_RESET = 7'd50;
  localparam logic [6:0] VOLUME_RESET  = 7'd20;
  localparam logic [3:0] HISTORY_RESET = 4'h3;

  // Movement per {previous pair, current pair}; 14 marks a bounce
  localparam logic signed [4:0] MOVE_TABLE [16] = '{
    5'sd0,  -5'sd1, 5'sd1,  5'sd14, 5'sd1,  5'sd0,  5'sd14, -5'sd1,
    -5'sd1, 5'sd14, 5'sd0,  5'sd1,  5'sd14, 5'sd1,  -5'sd1, 5'sd0
  };

  // One result item, laid out as it travels on the output stream
  typedef struct packed {
    logic [6:0] volume_level;
    logic       step_ccw;
    logic       step_valid;
  } qdvc_result_t;

endpackage

// ===== src/quadrature_detent_volume_counter_unit.sv =====
// Quadrature detent volume counter: top level with stream ports and output register.
// Depends on qdvc_pkg and qdvc_core.
//
// Each input transfer carries one sample of the encoder clock and data pins;
// each produces exactly one result transfer holding the step flag, the step
// direction and the volume after that sample. One sample is taken per clock
// cycle unless stalled; the decoder state updates at the input transfer and the
// result sits in a single output register, so it appears in the next cycle.
// Input is taken whenever the output register is empty or being emptied in the
// same cycle. Write the floor and ceiling limits only while no result is outstanding.
module quadrature_detent_volume_counter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] clk_level, [1] dt_level, [7:2] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] step_valid, [1] step_ccw, [8:2] volume_level, [15:9] zero
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [6:0]  wr_data
);
  import qdvc_pkg::*;

  logic         accept;
  qdvc_result_t result;
  qdvc_result_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  qdvc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .clk_level (s_tdata[0]),
    .dt_level  (s_tdata[1]),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .result    (result)
  );

  // Output valid: set on input transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {7'd0, out_reg};

`ifndef SYNTH
  a_ccw_implies_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("direction set without a step");

  a_result_follows_input: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(accept)) |-> m_tvalid)
    else $error("accepted sample produced no result");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(!accept && m_tvalid && m_tready)) |-> !m_tvalid)
    else $error("result repeated");
`endif

endmodule

// ===== src/qdvc_core.sv =====
// Decoder state, limit registers and per-sample update logic.
// Depends on qdvc_pkg.
module qdvc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  clk_level,
  input  logic                  dt_level,
  input  logic                  wr_en,
  input  logic                  wr_index,
  input  logic [6:0]            wr_data,
  output qdvc_pkg::qdvc_result_t result
);
  import qdvc_pkg::*;

  logic [6:0]        volume_floor;
  logic [6:0]        volume_ceiling;
  logic [3:0]        pin_history;
  logic signed [4:0] movement_sum;
  logic [6:0]        volume_count;

  logic [3:0]        pin_history_next;
  logic signed [4:0] move;
  logic signed [5:0] sum_wide;
  logic signed [4:0] movement_sum_next;
  logic              step_up;
  logic              step_down;
  logic [6:0]        volume_count_next;

  // Shift in the new pin pair and accumulate its movement
  always_comb begin
    pin_history_next = {pin_history[1:0], clk_level, dt_level};
    move             = MOVE_TABLE[pin_history_next];
    sum_wide         = {movement_sum[4], movement_sum} + {move[4], move};
    step_up          = 1'b0;
    step_down        = 1'b0;
    if (sum_wide[1:0] != 2'b00) begin
      // fold large sums down to 8 plus residue
      if (sum_wide >= 6'sd9) begin
        movement_sum_next = {3'b010, sum_wide[1:0]};
      end else begin
        movement_sum_next = sum_wide[4:0];
      end
    end else begin
      step_up           = (sum_wide == 6'sd4);
      step_down         = (sum_wide == -6'sd4);
      movement_sum_next = 5'sd0;
    end
  end

  // Saturating volume move
  always_comb begin
    volume_count_next = volume_count;
    if (step_up && (volume_count < volume_ceiling)) begin
      volume_count_next = volume_count + 7'd1;
    end else if (step_down && (volume_count > volume_floor)) begin
      volume_count_next = volume_count - 7'd1;
    end
  end

  assign result.step_valid   = step_up | step_down;
  assign result.step_ccw     = step_down;
  assign result.volume_level = volume_count_next;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_floor   <= FLOOR_RESET;
      volume_ceiling <= CEILING_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_VOLUME_FLOOR:   volume_floor   <= wr_data;
        REG_VOLUME_CEILING: volume_ceiling <= wr_data;
        default:            volume_floor   <= volume_floor;
      endcase
    end
  end

  // Advance decoder state on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_history  <= HISTORY_RESET;
      movement_sum <= 5'sd0;
      volume_count <= VOLUME_RESET;
    end else if (accept) begin
      pin_history  <= pin_history_next;
      movement_sum <= movement_sum_next;
      volume_count <= volume_count_next;
    end
  end

`ifndef SYNTH
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (movement_sum >= -5'sd3) && (movement_sum <= 5'sd11))
    else $error("movement sum left its range");

  a_volume_only_on_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (volume_count != $past(volume_count)))
      |-> $past(accept && (step_up || step_down)))
    else $error("volume moved without a step");

  a_volume_unit_move: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((volume_count == $past(volume_count))
      || (volume_count == $past(volume_count) + 7'd1)
      || (volume_count == $past(volume_count) - 7'd1)))
    else $error("volume moved by more than one");
`endif

endmodule

// ===== sim/tb_quadrature_detent_volume_counter_unit.sv =====
// Self-checking testbench for quadrature_detent_volume_counter_unit.
// Needs qdvc_pkg and the unit's RTL; drives encoder pin samples, predicts each
// result per accepted sample and compares them in order with the output stream.
module tb_quadrature_detent_volume_counter_unit;
  import qdvc_pkg::*;

  localparam int BOUNCE_DELTA = 14;
  // Movement per {previous pair, current pair}, pairs written as {clk, dt}
  localparam int PAIR_DELTA [16] = '{
    0, -1, 1, BOUNCE_DELTA, 1, 0, BOUNCE_DELTA, -1,
    -1, BOUNCE_DELTA, 0, 1, BOUNCE_DELTA, 1, -1, 0
  };
  // Clockwise detent cycle of pin pairs: 11, 01, 00, 10
  localparam logic GRAY_CLK [4] = '{1'b1, 1'b0, 1'b0, 1'b1};
  localparam logic GRAY_DT  [4] = '{1'b1, 1'b1, 1'b0, 1'b0};
  // Position in that cycle, indexed by {clk, dt}
  localparam int GRAY_POS [4] = '{2, 1, 3, 0};
  localparam int IDLE_LIMIT  = 2000;

  // One pin sample as it sits in tdata: clk_level in bit 0
  typedef struct packed {
    logic dt_level;
    logic clk_level;
  } pin_sample_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        wr_en    = 1'b0;
  logic        wr_index = REG_VOLUME_FLOOR;
  logic [6:0]  wr_data  = 7'd0;

  // Pending pin samples and predicted results
  pin_sample_t  pin_queue [$];
  qdvc_result_t volume_expect_q [$];

  // Predicted decoder state and limits
  logic [3:0] pair_hist  = HISTORY_RESET;
  int         travel_sum = 0;
  logic [6:0] vol_now    = VOLUME_RESET;
  logic [6:0] floor_now  = FLOOR_RESET;
  logic [6:0] ceil_now   = CEILING_RESET;

  // Bookkeeping
  int mismatches    = 0;
  int samples_taken = 0;
  int steps_up      = 0;
  int steps_down    = 0;
  int vol_low       = int'(VOLUME_RESET);
  int vol_high      = int'(VOLUME_RESET);
  int limit_sets    = 0;
  int idle_cycles   = 0;
  int send_wait     = 0;
  int send_calm     = 0;
  int ready_hold    = 0;
  int ready_calm    = 0;
  int gen_pos       = 0;
  int items_queued  = 0;

  quadrature_detent_volume_counter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 2) begin
      calm = $urandom_range(30, 90);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the predicted decoder by one pin sample
  function qdvc_result_t next_result(input logic clk_lvl, input logic dt_lvl);
    int           running;
    qdvc_result_t res;
    res = '0;
    pair_hist = {pair_hist[1:0], clk_lvl, dt_lvl};
    running = travel_sum + PAIR_DELTA[pair_hist];
    if (running % 4 != 0) begin
      // fold large sums, keeping the residue
      if (running >= 9) running = 8 + (running & 3);
      travel_sum = running;
    end else begin
      if (running == 4) begin
        res.step_valid = 1'b1;
      end else if (running == -4) begin
        res.step_valid = 1'b1;
        res.step_ccw   = 1'b1;
      end
      travel_sum = 0;
    end
    if (res.step_valid) begin
      if (res.step_ccw) begin
        steps_down++;
        if (vol_now > floor_now) vol_now = vol_now - 7'd1;
      end else begin
        steps_up++;
        if (vol_now < ceil_now) vol_now = vol_now + 7'd1;
      end
    end
    if (int'(vol_now) < vol_low) vol_low = int'(vol_now);
    if (int'(vol_now) > vol_high) vol_high = int'(vol_now);
    res.volume_level = vol_now;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Sender: present queued samples, pausing for random gaps
  always @(posedge clk) begin : sender
    pin_sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'd0;
      send_wait = 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pin_queue.size() != 0) begin
        nxt = pin_queue.pop_front();
        s_tdata  <= {6'd0, nxt};
        s_tvalid <= 1'b1;
        send_wait = pick_gap(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall the result stream at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      ready_hold = pick_gap(ready_calm);
    end
  end

  // Check each result transfer, then predict for each input transfer
  always @(posedge clk) begin : monitor
    qdvc_result_t seen;
    qdvc_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen = qdvc_result_t'(m_tdata[8:0]);
        if (volume_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got tdata %h", $time, m_tdata);
        end else begin
          want = volume_expect_q.pop_front();
          check_field("step_valid", int'(want.step_valid), int'(seen.step_valid));
          check_field("step_ccw", int'(want.step_ccw), int'(seen.step_ccw));
          check_field("volume_level", int'(want.volume_level), int'(seen.volume_level));
        end
      end
      if (s_tvalid && s_tready) begin
        samples_taken++;
        volume_expect_q.push_back(next_result(s_tdata[0], s_tdata[1]));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, volume_expect_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_pair(input logic clk_l, input logic dt_l);
    pin_sample_t smp;
    smp.clk_level = clk_l;
    smp.dt_level  = dt_l;
    pin_queue.push_back(smp);
    gen_pos = GRAY_POS[{clk_l, dt_l}];
    items_queued++;
  endtask

  // One quarter step along the detent cycle
  task automatic gray_step(input bit cw);
    int pos;
    pos = cw ? (gen_pos + 1) % 4 : (gen_pos + 3) % 4;
    push_pair(GRAY_CLK[pos], GRAY_DT[pos]);
  endtask

  // Mostly whole detents in a biased direction; the rest jitter, repeats and jumps
  task automatic run_random(input int n_items, input int up_pct);
    int target;
    int roll;
    bit cw;
    target = items_queued + n_items;
    while (items_queued < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        cw = ($urandom_range(0, 99) < up_pct);
        repeat (4) gray_step(cw);
      end else if (roll < 82) begin
        gray_step(1'($urandom_range(0, 1)));
      end else if (roll < 90) begin
        push_pair(GRAY_CLK[gen_pos], GRAY_DT[gen_pos]);
      end else begin
        push_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Hold until every sample is sent and every result has come back
  task automatic wait_idle();
    @(negedge clk);
    while (pin_queue.size() != 0 || s_tvalid || volume_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [6:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_VOLUME_FLOOR) floor_now = val;
    else ceil_now = val;
  endtask

  task automatic run_phase(input logic [6:0] lo, input logic [6:0] hi,
                           input int up_pct, input int n_items);
    wait_idle();
    write_limit(REG_VOLUME_FLOOR, lo);
    write_limit(REG_VOLUME_CEILING, hi);
    limit_sets++;
    run_random(n_items, up_pct);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: one detent each way at reset limits
    repeat (4) gray_step(1'b1);
    repeat (4) gray_step(1'b0);
    // Jitter back and forth, then a repeated pair
    gray_step(1'b1);
    gray_step(1'b0);
    push_pair(1'b1, 1'b1);
    // Bounces: diagonal jumps, a folded large sum, a cleared non-step multiple
    push_pair(1'b0, 1'b0);
    push_pair(1'b1, 1'b1);
    push_pair(1'b0, 1'b0);
    push_pair(1'b0, 1'b1);
    push_pair(1'b0, 1'b0);
    push_pair(1'b1, 1'b1);
    repeat (4) gray_step(1'b0);

    // Climb to the top, saturate there, then inverted and tight limits
    run_phase(7'd0, 7'd127, 95, 600);
    run_phase(7'd127, 7'd127, 90, 150);
    run_phase(7'd127, 7'd0, 50, 120);
    run_phase(7'd0, 7'd0, 5, 450);
    run_phase(7'd0, 7'd10, 50, 120);
    run_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 50, 180);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Checked %0d pin samples over %0d limit settings plus reset limits",
             samples_taken, limit_sets);
    $display("Predicted %0d up and %0d down detents; volume ranged %0d to %0d",
             steps_up, steps_down, vol_low, vol_high);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/qdvc_pkg.sv
src/qdvc_core.sv
src/quadrature_detent_volume_counter_unit.sv
sim/tb_quadrature_detent_volume_counter_unit.sv
